/* sv/brb_pkg.sv */
// Shared types and constants for the byte ring buffer.
package brb_pkg;

  localparam int unsigned DEPTH_DEF = 4096;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned LENGTH_W = 13;
  localparam int unsigned COUNT_W  = 12;

  localparam int unsigned LENGTH_MAX = (1 << LENGTH_W) - 1;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 64;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE    = 3'd0,
    OP_PEEK     = 3'd1,
    OP_ADV_TAIL = 3'd2,
    OP_ADV_HEAD = 3'd3,
    OP_CLEAR    = 3'd4
  } op_e;

  typedef struct packed {
    logic [COUNT_W-1:0] used;
    logic [COUNT_W-1:0] free;
    logic [COUNT_W-1:0] lin_used;
    logic [COUNT_W-1:0] lin_free;
  } status_t;

  typedef struct packed {
    logic fin;
    logic ok;
    logic rd;
  } done_t;

endpackage

/* sv/brb_ram.sv */
// Generic single-port RAM with a registered read.
module brb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/brb_ctrl.sv */
// Pointer control, operation decode, memory requests and fill counts.
module brb_ctrl #(
  parameter int unsigned DEPTH = brb_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [brb_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [brb_pkg::OFFSET_W-1:0]  offset_i,
  input  logic [brb_pkg::LENGTH_W-1:0]  length_i,
  input  logic                          pend_ready_i,
  output logic                          busy_o,
  output brb_pkg::done_t                done_o,
  output logic                          ram_we_o,
  output logic                          ram_re_o,
  output logic [AW-1:0]                 ram_addr_o,
  output brb_pkg::status_t              status_o
);

  function automatic int top_shift(int depth);
    int k;
    k = 0;
    while ((depth << (k + 1)) <= (depth - 1 + int'(brb_pkg::LENGTH_MAX))) begin
      k = k + 1;
    end
    return k;
  endfunction

  localparam int unsigned CW   = AW + 1;
  localparam int unsigned SW   = ((AW > brb_pkg::LENGTH_W) ? AW : brb_pkg::LENGTH_W) + 1;
  localparam bit          POW2 = ((DEPTH & (DEPTH - 1)) == 0);
  localparam int          KTOP = top_shift(int'(DEPTH));
  localparam int unsigned KW   = (KTOP > 0) ? $clog2(KTOP + 1) : 1;
  localparam bit          MULTI = !POW2 && (KTOP > 0);

  logic [AW-1:0] rp_q, rp_d, wp_q, wp_d;
  logic          busy_q, busy_d;
  logic [SW-1:0] red_q, red_d;
  logic [KW-1:0] k_q, k_d;
  logic          tail_q, tail_d;

  logic [CW-1:0] rp_e, wp_e, depth_c;
  logic [CW-1:0] used_w, free_w, lin_used_w, lin_free_w;
  logic [31:0]   len32;
  logic          off_in, wr_ok, pk_ok;
  logic [AW-1:0] ptr_sel;
  logic [SW-1:0] pos_sum, adv_sum, red_sub, depth_s;
  logic [AW-1:0] pos, adv_one, red_fin;
  logic [SW-1:0] red_step;

  assign rp_e    = CW'(rp_q);
  assign wp_e    = CW'(wp_q);
  assign depth_c = CW'(DEPTH);
  assign depth_s = SW'(DEPTH);

  always_comb begin
    used_w     = (wp_q >= rp_q) ? (wp_e - rp_e) : (wp_e + depth_c - rp_e);
    free_w     = depth_c - CW'(1) - used_w;
    lin_used_w = (wp_q == rp_q) ? '0 :
                 (rp_q < wp_q) ? (wp_e - rp_e) : (depth_c - rp_e);
    lin_free_w = (wp_q >= rp_q) ? (depth_c - CW'(1) - wp_e) : (rp_e - wp_e - CW'(1));
  end

  assign status_o.used     = brb_pkg::COUNT_W'(used_w);
  assign status_o.free     = brb_pkg::COUNT_W'(free_w);
  assign status_o.lin_used = brb_pkg::COUNT_W'(lin_used_w);
  assign status_o.lin_free = brb_pkg::COUNT_W'(lin_free_w);

  assign len32  = 32'(length_i);
  assign off_in = {1'b0, offset_i} < length_i;
  assign wr_ok  = (len32 <= 32'(free_w)) && off_in;
  assign pk_ok  = (len32 <= 32'(used_w)) && off_in;

  assign ptr_sel = (opcode_i == brb_pkg::OP_ADV_HEAD || opcode_i == brb_pkg::OP_PEEK) ?
                   rp_q : wp_q;

  always_comb begin
    pos_sum = SW'(ptr_sel) + SW'(offset_i);
    pos     = (pos_sum >= depth_s) ? AW'(pos_sum - depth_s) : AW'(pos_sum);
    adv_sum = SW'(ptr_sel) + SW'(length_i);
    if (POW2) begin
      adv_one = adv_sum[AW-1:0];
    end else begin
      adv_one = (adv_sum >= depth_s) ? AW'(adv_sum - depth_s) : AW'(adv_sum);
    end
    red_sub  = depth_s << k_q;
    red_step = (red_q >= red_sub) ? (red_q - red_sub) : red_q;
    red_fin  = AW'(red_step);
  end

  always_comb begin
    rp_d        = rp_q;
    wp_d        = wp_q;
    busy_d      = busy_q;
    red_d       = red_q;
    k_d         = k_q;
    tail_d      = tail_q;
    done_o      = '0;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = pos;
    if (busy_q) begin
      if (k_q == '0) begin
        if (pend_ready_i) begin
          if (tail_q) begin
            wp_d = red_fin;
          end else begin
            rp_d = red_fin;
          end
          busy_d     = 1'b0;
          done_o.fin = 1'b1;
        end
      end else begin
        red_d = red_step;
        k_d   = k_q - KW'(1);
      end
    end else if (fire_i) begin
      unique case (opcode_i)
        brb_pkg::OP_WRITE: begin
          done_o.fin = 1'b1;
          done_o.ok  = wr_ok;
          ram_we_o   = wr_ok;
        end
        brb_pkg::OP_PEEK: begin
          done_o.fin = 1'b1;
          done_o.ok  = pk_ok;
          done_o.rd  = pk_ok;
          ram_re_o   = pk_ok;
        end
        brb_pkg::OP_ADV_TAIL, brb_pkg::OP_ADV_HEAD: begin
          if (MULTI) begin
            busy_d = 1'b1;
            red_d  = adv_sum;
            k_d    = KW'(KTOP);
            tail_d = (opcode_i == brb_pkg::OP_ADV_TAIL);
          end else begin
            done_o.fin = 1'b1;
            if (opcode_i == brb_pkg::OP_ADV_TAIL) begin
              wp_d = adv_one;
            end else begin
              rp_d = adv_one;
            end
          end
        end
        brb_pkg::OP_CLEAR: begin
          done_o.fin = 1'b1;
          rp_d       = '0;
          wp_d       = '0;
        end
        default: begin
          done_o.fin = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q   <= '0;
      wp_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      rp_q   <= rp_d;
      wp_q   <= wp_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q  <= red_d;
    k_q    <= k_d;
    tail_q <= tail_d;
  end

  assign busy_o = busy_q;

endmodule

/* sv/byte_ring_buffer.sv */
// Top level of the byte ring buffer: stream ports, result pipeline and output register.
// A result beat passes the pending stage and then the output register before it becomes valid.
// The input takes one beat per cycle while the result path is free; with a depth that is not a
// power of two an advance stays busy through its modulo reduction loop in the pointer control.
// Reset clears both pointers and all valid flags; the byte memory is undefined until written.
module byte_ring_buffer #(
  parameter int unsigned DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // opcode[2:0], data_byte[10:3], offset[22:11], length[35:23], zero fill.
  input  logic [brb_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // read_byte[7:0], ok[8], used_count[20:9], free_count[32:21],
  // linear_used[44:33], linear_free[56:45], zero fill.
  output logic [brb_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [brb_pkg::OPCODE_W-1:0] opcode;
  logic [brb_pkg::BYTE_W-1:0]   data_byte;
  logic [brb_pkg::OFFSET_W-1:0] offset;
  logic [brb_pkg::LENGTH_W-1:0] length;

  logic             fire, busy, out_free, pend_ready;
  brb_pkg::done_t   done;
  brb_pkg::status_t status;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_addr;
  logic [brb_pkg::BYTE_W-1:0] rdata;

  logic pend_valid_q, pend_valid_d;
  logic pend_ok_q, pend_rd_q;
  logic out_valid_q, out_valid_d;
  logic [brb_pkg::BYTE_W-1:0] read_byte_q;
  logic             ok_q;
  brb_pkg::status_t status_q;

  assign opcode    = s_axis_tdata_i[2:0];
  assign data_byte = s_axis_tdata_i[10:3];
  assign offset    = s_axis_tdata_i[22:11];
  assign length    = s_axis_tdata_i[35:23];

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign pend_ready      = !pend_valid_q || out_free;
  assign s_axis_tready_o = pend_ready && !busy;
  assign fire            = s_axis_tvalid_i && s_axis_tready_o;

  brb_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .opcode_i     (opcode),
    .offset_i     (offset),
    .length_i     (length),
    .pend_ready_i (pend_ready),
    .busy_o       (busy),
    .done_o       (done),
    .ram_we_o     (ram_we),
    .ram_re_o     (ram_re),
    .ram_addr_o   (ram_addr),
    .status_o     (status)
  );

  brb_ram #(
    .WIDTH (brb_pkg::BYTE_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (data_byte),
    .rdata_o (rdata)
  );

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (done.fin) begin
      pend_valid_d = 1'b1;
    end else if (out_free) begin
      pend_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (pend_valid_q && out_free) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done.fin) begin
      pend_ok_q <= done.ok;
      pend_rd_q <= done.rd;
    end
    if (pend_valid_q && out_free) begin
      read_byte_q <= pend_rd_q ? rdata : '0;
      ok_q        <= pend_ok_q;
      status_q    <= status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, status_q.lin_free, status_q.lin_used,
                            status_q.free, status_q.used, ok_q, read_byte_q};

endmodule

/* tb/sv/byte_ring_buffer_test.sv */
// Self-checking stream testbench for the byte ring buffer with a built-in ring predictor.
`timescale 1ns / 1ps

module byte_ring_buffer_test;

  localparam int unsigned RING_DEPTH = brb_pkg::DEPTH_DEF;
  localparam int unsigned PHASE_ITEMS = 540;

  localparam logic [brb_pkg::OPCODE_W-1:0] OP_RSVD_A = 3'd5;
  localparam logic [brb_pkg::OPCODE_W-1:0] OP_RSVD_B = 3'd6;
  localparam logic [brb_pkg::OPCODE_W-1:0] OP_RSVD_C = 3'd7;

  typedef struct packed {
    logic [brb_pkg::OPCODE_W-1:0] opcode;
    logic [brb_pkg::BYTE_W-1:0]   data;
    logic [brb_pkg::OFFSET_W-1:0] offset;
    logic [brb_pkg::LENGTH_W-1:0] length;
  } cmd_t;

  typedef struct packed {
    logic [brb_pkg::BYTE_W-1:0]  rd;
    logic                        ok;
    logic [brb_pkg::COUNT_W-1:0] used;
    logic [brb_pkg::COUNT_W-1:0] free;
    logic [brb_pkg::COUNT_W-1:0] lin_used;
    logic [brb_pkg::COUNT_W-1:0] lin_free;
  } ring_res_t;

  typedef struct packed {
    cmd_t      cmd;
    logic      typed;
    ring_res_t res;
  } dir_row_t;

  localparam ring_res_t RES_NONE  = '0;
  localparam ring_res_t RES_EMPTY = '{8'h00, 1'b0, 12'd0, 12'd4095, 12'd0, 12'd4095};
  localparam ring_res_t RES_STORE = '{8'h00, 1'b1, 12'd0, 12'd4095, 12'd0, 12'd4095};
  localparam ring_res_t RES_TWO   = '{8'h00, 1'b0, 12'd2, 12'd4093, 12'd2, 12'd4093};
  localparam ring_res_t RES_FULL  = '{8'h00, 1'b0, 12'd4095, 12'd0, 12'd4095, 12'd0};

  logic                            clk_i;
  logic                            rst_ni   = 1'b0;
  logic                            s_tvalid = 1'b0;
  logic [brb_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                            s_axis_tready_o;
  logic                            m_axis_tvalid_o;
  logic                            m_tready = 1'b0;
  logic [brb_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;

  byte_ring_buffer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  logic [brb_pkg::BYTE_W-1:0] ring_mem     [RING_DEPTH];
  bit                         ring_written [RING_DEPTH];
  int unsigned                ring_head = 0;
  int unsigned                ring_tail = 0;

  ring_res_t predicted_beats [$];
  int        mismatches      = 0;
  int        items_sent      = 0;
  int        sender_idle_pct = 0;
  int        recv_idle_pct   = 0;

  dir_row_t directed_rows [0:25] = '{
    '{'{brb_pkg::OP_PEEK,     8'h00, 12'h000, 13'd0},    1'b1, RES_EMPTY},
    '{'{brb_pkg::OP_WRITE,    8'hFF, 12'h000, 13'd4096}, 1'b1, RES_EMPTY},
    '{'{brb_pkg::OP_WRITE,    8'hFF, 12'h000, 13'd0},    1'b1, RES_EMPTY},
    '{'{brb_pkg::OP_WRITE,    8'hA5, 12'h000, 13'd2},    1'b1, RES_STORE},
    '{'{brb_pkg::OP_WRITE,    8'h5A, 12'h001, 13'd2},    1'b1, RES_STORE},
    '{'{brb_pkg::OP_WRITE,    8'h00, 12'hFFF, 13'd2},    1'b1, RES_EMPTY},
    '{'{brb_pkg::OP_PEEK,     8'h00, 12'h000, 13'd1},    1'b1, RES_EMPTY},
    '{'{brb_pkg::OP_ADV_TAIL, 8'h00, 12'h000, 13'd2},    1'b1, RES_TWO},
    '{'{brb_pkg::OP_PEEK,     8'h00, 12'h001, 13'd2},    1'b1,
      '{8'h5A, 1'b1, 12'd2, 12'd4093, 12'd2, 12'd4093}},
    '{'{brb_pkg::OP_PEEK,     8'h00, 12'h000, 13'd3},    1'b1, RES_TWO},
    '{'{brb_pkg::OP_PEEK,     8'h00, 12'h002, 13'd2},    1'b1, RES_TWO},
    '{'{brb_pkg::OP_ADV_HEAD, 8'h00, 12'h000, 13'd1},    1'b1,
      '{8'h00, 1'b0, 12'd1, 12'd4094, 12'd1, 12'd4093}},
    '{'{OP_RSVD_A,            8'hFF, 12'hFFF, 13'h1FFF}, 1'b0, RES_NONE},
    '{'{OP_RSVD_B,            8'h00, 12'h000, 13'd1},    1'b0, RES_NONE},
    '{'{OP_RSVD_C,            8'hFF, 12'hFFF, 13'd0},    1'b0, RES_NONE},
    '{'{brb_pkg::OP_ADV_TAIL, 8'h00, 12'h000, 13'h1FFF}, 1'b0, RES_NONE},
    '{'{brb_pkg::OP_CLEAR,    8'h00, 12'h000, 13'd0},    1'b1, RES_EMPTY},
    '{'{brb_pkg::OP_ADV_TAIL, 8'h00, 12'h000, 13'd4095}, 1'b1, RES_FULL},
    '{'{brb_pkg::OP_WRITE,    8'h01, 12'h000, 13'd1},    1'b1, RES_FULL},
    '{'{brb_pkg::OP_ADV_HEAD, 8'h00, 12'h000, 13'd4094}, 1'b0, RES_NONE},
    '{'{brb_pkg::OP_ADV_HEAD, 8'h00, 12'h000, 13'd4096}, 1'b0, RES_NONE},
    '{'{brb_pkg::OP_WRITE,    8'hC3, 12'h003, 13'd4},    1'b0, RES_NONE},
    '{'{brb_pkg::OP_WRITE,    8'h81, 12'h000, 13'd4},    1'b0, RES_NONE},
    '{'{brb_pkg::OP_ADV_TAIL, 8'h00, 12'h000, 13'd4},    1'b0, RES_NONE},
    '{'{brb_pkg::OP_PEEK,     8'h00, 12'h004, 13'd5},    1'b0, RES_NONE},
    '{'{brb_pkg::OP_PEEK,     8'h00, 12'h001, 13'd5},    1'b0, RES_NONE}
  };

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("byte_ring_buffer_test NOT OK");
    $finish;
  end

  function automatic int unsigned ring_used();
    return (ring_tail + RING_DEPTH - ring_head) % RING_DEPTH;
  endfunction

  function automatic int unsigned ring_free();
    return RING_DEPTH - ring_used() - 1;
  endfunction

  function automatic ring_res_t ring_apply(input cmd_t c);
    ring_res_t   r;
    int unsigned pos;
    r = '0;
    unique case (c.opcode)
      brb_pkg::OP_WRITE: begin
        if (c.length <= ring_free() && c.offset < c.length) begin
          pos = (ring_tail + c.offset) % RING_DEPTH;
          ring_mem[pos]     = c.data;
          ring_written[pos] = 1'b1;
          r.ok              = 1'b1;
        end
      end
      brb_pkg::OP_PEEK: begin
        if (ring_used() >= c.length && c.offset < c.length) begin
          pos  = (ring_head + c.offset) % RING_DEPTH;
          r.rd = ring_mem[pos];
          r.ok = 1'b1;
        end
      end
      brb_pkg::OP_ADV_TAIL: ring_tail = (ring_tail + c.length) % RING_DEPTH;
      brb_pkg::OP_ADV_HEAD: ring_head = (ring_head + c.length) % RING_DEPTH;
      brb_pkg::OP_CLEAR: begin
        ring_head = 0;
        ring_tail = 0;
      end
      default: ;
    endcase
    r.used = brb_pkg::COUNT_W'(ring_used());
    r.free = brb_pkg::COUNT_W'(ring_free());
    if (ring_tail == ring_head) begin
      r.lin_used = '0;
    end else if (ring_head < ring_tail) begin
      r.lin_used = brb_pkg::COUNT_W'(ring_tail - ring_head);
    end else begin
      r.lin_used = brb_pkg::COUNT_W'(RING_DEPTH - ring_head);
    end
    if (ring_tail >= ring_head) begin
      r.lin_free = brb_pkg::COUNT_W'(RING_DEPTH - ring_tail - 1);
    end else begin
      r.lin_free = brb_pkg::COUNT_W'(ring_head - ring_tail - 1);
    end
    return r;
  endfunction

  task automatic send_cmd(input cmd_t c, input logic typed, input ring_res_t typed_res);
    ring_res_t   want;
    int unsigned pos;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    // A successful peek must never land on a byte that was never stored.
    pos = (ring_head + c.offset) % RING_DEPTH;
    if (c.opcode == brb_pkg::OP_PEEK && ring_used() >= c.length && c.offset < c.length &&
        !ring_written[pos]) begin
      c.length = '0;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= brb_pkg::IN_TDATA_W'({c.length, c.offset, c.data, c.opcode});
    do @(posedge clk_i); while (!s_axis_tready_o);
    want = ring_apply(c);
    predicted_beats.push_back(typed ? typed_res : want);
    items_sent++;
  endtask

  task automatic run_traffic(input int target);
    int   n;
    int   pick;
    int   j;
    int   tmp;
    int   order [];
    cmd_t c;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      n = ($urandom_range(9) == 0) ? $urandom_range(400, 17) : $urandom_range(16, 1);
      if (pick < 42) begin
        if ($urandom_range(9) != 0 && n > ring_free()) n = ring_free();
        if (n == 0) n = 1;
        order = new[n];
        foreach (order[i]) order[i] = i;
        for (int i = n - 1; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        foreach (order[i]) begin
          c = '{brb_pkg::OP_WRITE, 8'($urandom), 12'(order[i]), 13'(n)};
          send_cmd(c, 1'b0, RES_NONE);
        end
        if ($urandom_range(15) != 0) send_cmd('{brb_pkg::OP_ADV_TAIL, 8'($urandom),
                                              12'($urandom), 13'(n)}, 1'b0, RES_NONE);
      end else if (pick < 78) begin
        if ($urandom_range(9) != 0 && n > ring_used()) n = ring_used();
        if (n == 0) n = 1;
        for (int i = 0; i < n; i++) begin
          c = '{brb_pkg::OP_PEEK, 8'($urandom), 12'(i), 13'(n)};
          if ($urandom_range(7) == 0) c.offset = 12'($urandom_range(n - 1));
          send_cmd(c, 1'b0, RES_NONE);
        end
        if ($urandom_range(15) != 0) send_cmd('{brb_pkg::OP_ADV_HEAD, 8'($urandom),
                                              12'($urandom), 13'(n)}, 1'b0, RES_NONE);
      end else begin
        c = '{3'($urandom_range(7)), 8'($urandom), 12'($urandom), 13'($urandom_range(64))};
        if ($urandom_range(3) == 0) c.length = 13'($urandom);
        send_cmd(c, 1'b0, RES_NONE);
      end
    end
  endtask

  always @(posedge clk_i) begin
    ring_res_t got;
    ring_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got = '{m_axis_tdata_o[7:0], m_axis_tdata_o[8], m_axis_tdata_o[20:9],
              m_axis_tdata_o[32:21], m_axis_tdata_o[44:33], m_axis_tdata_o[56:45]};
      if (predicted_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result beat with nothing expected: %h", $realtime,
                                       got);
      end else begin
        want = predicted_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch rd %h/%h ok %b/%b used %0d/%0d free %0d/%0d",
                     $realtime, want.rd, got.rd, want.ok, got.ok, want.used, got.used,
                     want.free, got.free);
            $display("  lin_used %0d/%0d lin_free %0d/%0d (expected/actual)",
                     want.lin_used, got.lin_used, want.lin_free, got.lin_free);
          end
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    int snd_pct [3];
    int rcv_pct [3];
    snd_pct = '{37, 62, 0};
    rcv_pct = '{62, 37, 0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < 3; p++) begin
      sender_idle_pct = snd_pct[p];
      recv_idle_pct   = rcv_pct[p];
      if (p == 0) begin
        foreach (directed_rows[i]) begin
          send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);
        end
      end
      run_traffic(items_sent + PHASE_ITEMS);
      s_tvalid <= 1'b0;
      while (predicted_beats.size() != 0) @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && predicted_beats.size() == 0) begin
      $display("byte_ring_buffer_test OK");
    end else begin
      $display("byte_ring_buffer_test NOT OK");
    end
    $finish;
  end

endmodule
